FILE: sv/bdq_pkg.sv
package bdq_pkg;

    // Default sizes of the queue.
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Widths of the fixed payload fields.
    localparam int KIND_W     = 3;
    localparam int VALUE_W    = 32;
    localparam int OUT_DATA_W = 32;
    localparam int COUNT_W    = 5;
    localparam int STATUS_W   = 2;

    // Cells are grouped for the first-hit selection.
    localparam int GRP_SIZE  = 16;
    localparam int GRP_IDX_W = $clog2(GRP_SIZE);

    // Operation kinds.
    localparam logic [KIND_W-1:0] KIND_PUSH    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_POP     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_UNSHIFT = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SHIFT   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DELETE  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_COUNT   = 3'd5;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd3;

    // What each cell does with its word in a cycle.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_INSERT,
        CELL_CLOSE
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t cmd;
        logic      tail_sel;
    } bdq_cell_ctrl_t;

endpackage

FILE: sv/bdq_cell.sv
module bdq_cell
    import bdq_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int CNT_W      = $clog2(DEPTH_DEF + 1),
    parameter int INDEX      = 0
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  bdq_cell_ctrl_t        ctrl,
    input  logic [CNT_W-1:0]      cmp_pos,
    input  logic [CNT_W-1:0]      wr_pos,
    input  logic [DATA_WIDTH-1:0] value,
    input  logic [DATA_WIDTH-1:0] left,
    input  logic [DATA_WIDTH-1:0] right,
    output logic [DATA_WIDTH-1:0] data,
    output logic                  hit
);

    localparam logic [CNT_W-1:0] MY_POS = CNT_W'(INDEX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  hit_reg;
    logic                  hit_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.cmd)
            CELL_WRITE:
            begin
                if (MY_POS == wr_pos)
                begin
                    data_next = value;
                end
            end
            CELL_INSERT:
            begin
                data_next = (INDEX == 0) ? value : left;
            end
            CELL_CLOSE:
            begin
                if (MY_POS >= wr_pos)
                begin
                    data_next = right;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // Either this cell is the tail, or it holds a live word equal to the key.
    always_comb
    begin
        if (ctrl.tail_sel)
        begin
            hit_next = (MY_POS == cmp_pos);
        end
        else
        begin
            hit_next = (data_reg == value) && (MY_POS < cmp_pos);
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    assign data = data_reg;
    assign hit  = hit_reg;

endmodule

FILE: sv/bdq_group.sv
module bdq_group
    import bdq_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int GW         = GRP_SIZE
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [GW-1:0]                  hit,
    input  logic [GW-1:0][DATA_WIDTH-1:0]  data,
    output logic                           any,
    output logic [GRP_IDX_W-1:0]           idx,
    output logic [DATA_WIDTH-1:0]          sel_data
);

    logic                  any_reg;
    logic                  any_next;
    logic [GRP_IDX_W-1:0]  idx_reg;
    logic [GRP_IDX_W-1:0]  idx_next;
    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    // Lowest hitting cell of the group wins.
    always_comb
    begin
        any_next  = 1'b0;
        idx_next  = '0;
        data_next = '0;
        for (int i = GW - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                any_next  = 1'b1;
                idx_next  = GRP_IDX_W'(i);
                data_next = data[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            any_reg <= 1'b0;
        end
        else
        begin
            any_reg <= any_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        data_reg <= data_next;
    end

    assign any      = any_reg;
    assign idx      = idx_reg;
    assign sel_data = data_reg;

endmodule

FILE: sv/bounded_deque_with_delete_unit.sv
// Bounded double-ended queue of up to DEPTH words, with delete by value.
// The input channel (in_valid, in_ready, kind, value) carries one operation per
// transaction; the output channel (out_valid, out_ready, data_out, entry_count,
// status) returns exactly one result transaction for each, in order.
// The words live in a row of cells, head in cell 0; each cell loads the new
// word, takes its left or right neighbour's word, or holds, so inserts at the
// head and the closing of a gap after shift or delete are done by all cells together.
// The block works on one operation at a time. Push, unshift, shift, count and
// any operation that fails at once go from taking the transaction in straight
// to executing it. Pop and delete on a non-empty queue first pass through the
// registered compare in every cell and then the registered first-hit selection
// over groups of sixteen cells.
// The result appears in the output register in the execute cycle and is
// visible from the next edge. While an earlier result is still waiting there,
// an operation that reaches execution stalls until out_ready frees the register.
// Reset (rst_n low, asynchronous) empties the queue, drops any pending result
// and leaves the block ready; the cell contents are not cleared.
module bounded_deque_with_delete_unit
    import bdq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [KIND_W-1:0]     kind,
    input  logic [VALUE_W-1:0]    value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] data_out,
    output logic [COUNT_W-1:0]    entry_count,
    output logic [STATUS_W-1:0]   status
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int NGRP  = (DEPTH + GRP_SIZE - 1) / GRP_SIZE;

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_GRP  = 2'd2;
    localparam logic [1:0] S_EXEC = 2'd3;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [CNT_W-1:0]      occ_reg;
    logic [CNT_W-1:0]      occ_next;
    logic [KIND_W-1:0]     kind_reg;
    logic [KIND_W-1:0]     kind_next;
    logic [DATA_WIDTH-1:0] value_reg;
    logic [DATA_WIDTH-1:0] value_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OUT_DATA_W-1:0] data_out_reg;
    logic [OUT_DATA_W-1:0] data_out_next;
    logic [COUNT_W-1:0]    entry_count_reg;
    logic [COUNT_W-1:0]    entry_count_next;
    logic [STATUS_W-1:0]   status_reg;
    logic [STATUS_W-1:0]   status_next;

    bdq_cell_ctrl_t        cell_ctrl;
    logic [CNT_W-1:0]      cmp_pos;
    logic [CNT_W-1:0]      wr_pos;
    logic [DEPTH-1:0]                  hit_vec;
    logic [DEPTH-1:0][DATA_WIDTH-1:0]  data_row;

    logic [NGRP-1:0]                   grp_any;
    logic [NGRP-1:0][GRP_IDX_W-1:0]    grp_idx;
    logic [NGRP-1:0][DATA_WIDTH-1:0]   grp_data;

    logic                  found;
    logic [IDX_W-1:0]      found_pos;
    logic [DATA_WIDTH-1:0] found_data;

    logic                  full;
    logic                  empty;
    logic                  out_free;
    logic [DATA_WIDTH-1:0] res_data;
    logic [STATUS_W-1:0]   res_status;

    // The row of cells. The head cell takes the new word on an unshift, and
    // the tail cell refills from itself when the row closes up.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_d;
        logic [DATA_WIDTH-1:0] right_d;

        if (i == 0)
        begin : g_head
            assign left_d = value_reg;
        end
        else
        begin : g_inner_l
            assign left_d = data_row[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_d = data_row[i];
        end
        else
        begin : g_inner_r
            assign right_d = data_row[i+1];
        end

        bdq_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CNT_W      (CNT_W),
            .INDEX      (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (cell_ctrl),
            .cmp_pos (cmp_pos),
            .wr_pos  (wr_pos),
            .value   (value_reg),
            .left    (left_d),
            .right   (right_d),
            .data    (data_row[i]),
            .hit     (hit_vec[i])
        );
    end

    // First-hit selection within each group of cells, registered.
    for (genvar g = 0; g < NGRP; g++)
    begin : g_grp
        localparam int GW = (DEPTH - g * GRP_SIZE < GRP_SIZE) ?
                            (DEPTH - g * GRP_SIZE) : GRP_SIZE;

        bdq_group #(
            .DATA_WIDTH (DATA_WIDTH),
            .GW         (GW)
        ) u_grp (
            .clk      (clk),
            .rst_n    (rst_n),
            .hit      (hit_vec[g*GRP_SIZE +: GW]),
            .data     (data_row[g*GRP_SIZE +: GW]),
            .any      (grp_any[g]),
            .idx      (grp_idx[g]),
            .sel_data (grp_data[g])
        );
    end

    // The lowest group with a hit gives the position and word of the match.
    always_comb
    begin
        found      = 1'b0;
        found_pos  = '0;
        found_data = '0;
        for (int g = NGRP - 1; g >= 0; g--)
        begin
            if (grp_any[g])
            begin
                found      = 1'b1;
                found_pos  = IDX_W'(g * GRP_SIZE) + IDX_W'(grp_idx[g]);
                found_data = grp_data[g];
            end
        end
    end

    assign full     = (occ_reg == CNT_W'(DEPTH));
    assign empty    = (occ_reg == '0);
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    // The compare set-up follows the held operation, so the cell hits stay
    // valid for as long as the execute step is stalled.
    assign cmp_pos = (kind_reg == KIND_POP) ? (occ_reg - CNT_W'(1)) : occ_reg;

    always_comb
    begin
        state_next       = state_reg;
        occ_next         = occ_reg;
        kind_next        = kind_reg;
        value_next       = value_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        data_out_next    = data_out_reg;
        entry_count_next = entry_count_reg;
        status_next      = status_reg;
        cell_ctrl.cmd      = CELL_HOLD;
        cell_ctrl.tail_sel = (kind_reg == KIND_POP);
        wr_pos           = occ_reg;
        res_data         = '0;
        res_status       = ST_OK;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next  = kind;
                    value_next = DATA_WIDTH'(value);
                    if ((kind inside {KIND_POP, KIND_DELETE}) && !empty)
                    begin
                        state_next = S_CMP;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_CMP:
            begin
                state_next = S_GRP;
            end
            S_GRP:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    case (kind_reg)
                        KIND_PUSH:
                        begin
                            if (full)
                            begin
                                res_status = ST_FULL;
                            end
                            else
                            begin
                                cell_ctrl.cmd = CELL_WRITE;
                                wr_pos        = occ_reg;
                                occ_next      = occ_reg + CNT_W'(1);
                            end
                        end
                        KIND_POP:
                        begin
                            if (empty)
                            begin
                                res_status = ST_EMPTY;
                            end
                            else
                            begin
                                res_data = found_data;
                                occ_next = occ_reg - CNT_W'(1);
                            end
                        end
                        KIND_UNSHIFT:
                        begin
                            if (full)
                            begin
                                res_status = ST_FULL;
                            end
                            else
                            begin
                                cell_ctrl.cmd = CELL_INSERT;
                                occ_next      = occ_reg + CNT_W'(1);
                            end
                        end
                        KIND_SHIFT:
                        begin
                            if (empty)
                            begin
                                res_status = ST_EMPTY;
                            end
                            else
                            begin
                                res_data      = data_row[0];
                                cell_ctrl.cmd = CELL_CLOSE;
                                wr_pos        = '0;
                                occ_next      = occ_reg - CNT_W'(1);
                            end
                        end
                        KIND_DELETE:
                        begin
                            // An empty queue skips the search, so the group
                            // results are not looked at then.
                            if (!empty && found)
                            begin
                                cell_ctrl.cmd = CELL_CLOSE;
                                wr_pos        = CNT_W'(found_pos);
                                occ_next      = occ_reg - CNT_W'(1);
                            end
                            else
                            begin
                                res_status = ST_NOMATCH;
                            end
                        end
                        default:
                        begin
                            // Count and the unused kinds leave the queue alone.
                            res_status = ST_OK;
                        end
                    endcase
                    out_valid_next   = 1'b1;
                    data_out_next    = OUT_DATA_W'(res_data);
                    entry_count_next = COUNT_W'(occ_next);
                    status_next      = res_status;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        value_reg       <= value_next;
        data_out_reg    <= data_out_next;
        entry_count_reg <= entry_count_next;
        status_reg      <= status_next;
    end

    assign out_valid   = out_valid_reg;
    assign data_out    = data_out_reg;
    assign entry_count = entry_count_reg;
    assign status      = status_reg;

`ifndef NO_ASSERTIONS
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(DEPTH))
        else $error("occupancy exceeds the queue depth");

    a_pop_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && kind_reg == KIND_POP && !empty) |-> found)
        else $error("pop on a non-empty queue found no tail cell");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_FULL) |-> entry_count_reg == COUNT_W'(DEPTH))
        else $error("full status reported below the queue depth");

    a_occ_change: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg != $past(occ_reg)) |-> $past(state_reg == S_EXEC))
        else $error("occupancy changed outside the execute step");
`endif

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import bdq_pkg::*;

    localparam int DEPTH      = DEPTH_DEF;
    localparam int DATA_WIDTH = DATA_WIDTH_DEF;

    // Kind codes six and seven are not assigned. The block must treat them as a count.
    localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

    // Traffic mixes used by the random part.
    localparam int MIX_FILL    = 0;
    localparam int MIX_DRAIN   = 1;
    localparam int MIX_BALANCE = 2;

    localparam int RANDOM_ITEMS = 1130;
    localparam int SETTLE_CYCLES = 16;
    // The slowest correct item is a pop or delete with a long gap on each side.
    // The limit below is several times what about 1150 such items take.
    localparam int CYCLE_LIMIT = 500000;

    typedef struct packed {
        logic [OUT_DATA_W-1:0] data;
        logic [COUNT_W-1:0]    count;
        logic [STATUS_W-1:0]   status;
    } deque_result_t;

    // Mirror of the queue contents. It also holds the results still awaited
    // from the block, in order.
    class deque_mirror;
        logic [DATA_WIDTH-1:0] words[$];
        deque_result_t         awaited[$];
        int                    mismatches;

        function void apply_op(logic [KIND_W-1:0] op, logic [VALUE_W-1:0] operand);
            logic [DATA_WIDTH-1:0] word;
            deque_result_t         res;
            int                    hit;
            word = operand[DATA_WIDTH-1:0];
            res  = '0;
            res.status = ST_OK;
            case (op)
                KIND_PUSH, KIND_UNSHIFT: begin
                    if (words.size() >= DEPTH)
                        res.status = ST_FULL;
                    else if (op == KIND_PUSH)
                        words.push_back(word);
                    else
                        words.push_front(word);
                end
                KIND_POP, KIND_SHIFT: begin
                    if (words.size() == 0)
                        res.status = ST_EMPTY;
                    else if (op == KIND_POP)
                        res.data = OUT_DATA_W'(words.pop_back());
                    else
                        res.data = OUT_DATA_W'(words.pop_front());
                end
                KIND_DELETE: begin
                    hit = -1;
                    for (int i = 0; i < words.size(); i++)
                        if (hit < 0 && words[i] == word)
                            hit = i;
                    if (hit < 0)
                        res.status = ST_NOMATCH;
                    else
                        words.delete(hit);
                end
                default: ;
            endcase
            res.count = COUNT_W'(words.size());
            awaited.push_back(res);
        endfunction

        function void note_mismatch(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t mismatch: %s", $time, what);
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] d, logic [COUNT_W-1:0] c,
                                   logic [STATUS_W-1:0] s);
            deque_result_t want;
            if (awaited.size() == 0) begin
                note_mismatch($sformatf("unexpected result data %h count %0d status %0d",
                                        d, c, s));
                return;
            end
            want = awaited.pop_front();
            if (want.data !== d || want.count !== c || want.status !== s)
                note_mismatch($sformatf(
                    "expected data %h count %0d status %0d, got data %h count %0d status %0d",
                    want.data, want.count, want.status, d, c, s));
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [KIND_W-1:0]     kind = KIND_COUNT;
    logic [VALUE_W-1:0]    value = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [OUT_DATA_W-1:0] data_out;
    logic [COUNT_W-1:0]    entry_count;
    logic [STATUS_W-1:0]   status;

    deque_mirror mirror = new();
    bit          calm = 1'b0;   // when set, neither side inserts any gaps
    int          cycle_count = 0;

    bounded_deque_with_delete_unit #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .data_out    (data_out),
        .entry_count (entry_count),
        .status      (status)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // This is a watchdog. A hung handshake must not keep the run alive for ever.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[bounded_deque_with_delete_unit] ERROR");
            $finish;
        end
    end

    // Gap lengths are mostly zero or short. Now and then a long one appears,
    // so that pauses fall on every phase of the block's short and long operations.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // The result side is paced here. out_ready drops for a random stretch,
    // then stays high for another random stretch, and so on. Each step makes at most
    // one assignment.
    initial begin : sink_pacing
        int hold;
        @(posedge rst_n);
        forever begin
            hold = pick_gap();
            if (hold > 0) begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    end

    // The result monitor samples at the edge. All inputs are driven with
    // nonblocking assignments, so it sees the values from before the edge.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            mirror.check_result(data_out, entry_count, status);
    end

    // This task offers one transaction and holds it until it is accepted. The
    // expected result is recorded at the accepting edge. in_valid is lowered only
    // when a gap follows. Back-to-back transactions therefore keep it high and
    // never assign it twice in one step.
    task automatic send_op(input logic [KIND_W-1:0] op, input logic [VALUE_W-1:0] operand);
        int gap;
        in_valid <= 1'b1;
        kind     <= op;
        value    <= operand;
        do
            @(posedge clk);
        while (!in_ready);
        mirror.apply_op(op, operand);
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Each mix is weighted so that the queue drifts towards full or towards
    // empty. The random part then spends time at both boundaries.
    function automatic logic [KIND_W-1:0] pick_kind(int mix);
        int r;
        int w_push;
        int w_unshift;
        int w_pop;
        int w_shift;
        int w_delete;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  begin w_push = 35; w_unshift = 30; w_pop = 10; w_shift = 10; w_delete = 10; end
            MIX_DRAIN: begin w_push = 10; w_unshift = 10; w_pop = 25; w_shift = 25; w_delete = 22; end
            default:   begin w_push = 20; w_unshift = 20; w_pop = 18; w_shift = 18; w_delete = 18; end
        endcase
        if (r < w_push)
            return KIND_PUSH;
        r -= w_push;
        if (r < w_unshift)
            return KIND_UNSHIFT;
        r -= w_unshift;
        if (r < w_pop)
            return KIND_POP;
        r -= w_pop;
        if (r < w_shift)
            return KIND_SHIFT;
        r -= w_shift;
        if (r < w_delete)
            return KIND_DELETE;
        case ($urandom_range(0, 2))
            0:       return KIND_COUNT;
            1:       return KIND_SPARE_A;
            default: return KIND_SPARE_B;
        endcase
    endfunction

    // Small values give duplicates, so a delete removes only the first match.
    // Full-width random values make every bit of the word toggle. A delete
    // often aims at a word the queue actually holds.
    function automatic logic [VALUE_W-1:0] pick_value(logic [KIND_W-1:0] op);
        int r;
        r = $urandom_range(0, 99);
        if (op == KIND_DELETE && mirror.words.size() > 0 && r < 60)
            return VALUE_W'(mirror.words[$urandom_range(0, mirror.words.size() - 1)]);
        if (r < 40)
            return VALUE_W'($urandom_range(0, 7));
        if (r < 45)
            return '0;
        if (r < 50)
            return '1;
        return $urandom();
    endfunction

    initial begin : stimulus
        int               issued;
        int               stretch;
        int               mix;
        logic [KIND_W-1:0] op;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. It starts with a count and every removal kind on an
        // empty queue, then the two unassigned kinds. Next come deletes that
        // hit the head, the tail and the middle, and a delete that finds no
        // match. The extremes of the data word are included, and the part ends
        // by draining back to empty.
        send_op(KIND_COUNT, 32'h0000_0000);
        send_op(KIND_POP, 32'h0000_0000);
        send_op(KIND_SHIFT, 32'hFFFF_FFFF);
        send_op(KIND_DELETE, 32'h0000_0000);
        send_op(KIND_SPARE_A, 32'hFFFF_FFFF);
        send_op(KIND_SPARE_B, 32'h1234_5678);
        send_op(KIND_PUSH, 32'hFFFF_FFFF);
        send_op(KIND_PUSH, 32'h0000_0000);
        send_op(KIND_UNSHIFT, 32'h1234_5678);
        send_op(KIND_UNSHIFT, 32'h0000_0000);
        send_op(KIND_DELETE, 32'h0000_0000);
        send_op(KIND_DELETE, 32'h0000_0000);
        send_op(KIND_DELETE, 32'hAAAA_AAAA);
        send_op(KIND_PUSH, 32'h5555_5555);
        send_op(KIND_PUSH, 32'hAAAA_AAAA);
        send_op(KIND_DELETE, 32'hFFFF_FFFF);
        send_op(KIND_POP, 32'h0000_0000);
        send_op(KIND_SHIFT, 32'h0000_0000);
        send_op(KIND_COUNT, 32'hFFFF_FFFF);
        send_op(KIND_SHIFT, 32'h0000_0000);
        send_op(KIND_POP, 32'h0000_0000);

        // Random part. Phases of 20 to 60 transactions use one mix each. About
        // a quarter of the phases run with no gaps on either side.
        issued = 0;
        while (issued < RANDOM_ITEMS) begin
            mix     = $urandom_range(MIX_FILL, MIX_BALANCE);
            calm    = ($urandom_range(0, 3) == 0);
            stretch = $urandom_range(20, 60);
            for (int n = 0; n < stretch && issued < RANDOM_ITEMS; n++) begin
                op = pick_kind(mix);
                send_op(op, pick_value(op));
                issued++;
            end
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        // Wait for every outstanding result, then allow a short window in
        // which any extra result would be caught.
        while (mirror.awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mirror.mismatches == 0 && mirror.awaited.size() == 0)
            $display("[bounded_deque_with_delete_unit] OK");
        else
            $display("[bounded_deque_with_delete_unit] ERROR");
        $finish;
    end

endmodule

FILE: files.f
sv/bdq_pkg.sv
sv/bdq_cell.sv
sv/bdq_group.sv
sv/bounded_deque_with_delete_unit.sv
sim/tb_top.sv
